>>> rtl/bhcb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bhcb_pkg;

  localparam int unsigned LIMIT_W     = 11;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned DELTA_W     = 11;
  localparam int unsigned INDEX_W     = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned REQ_W       = 3;
  localparam int unsigned MIN_LIMIT   = 8;
  localparam int unsigned LIMIT_RESET = 1000;
  localparam int unsigned APB_AW      = 3;
  localparam int unsigned APB_DW      = 32;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH,
    REQ_MOVE,
    REQ_SET,
    REQ_READ,
    REQ_CLEAR
  } req_e;

  typedef struct packed {
    logic load;
    logic trim;
    logic exec;
    logic rd_pair;
    logic rd_tgt;
  } bhcb_cmd_t;

endpackage

`default_nettype wire

>>> rtl/bhcb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bhcb_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  output logic                     result_valid_o,
  output bhcb_pkg::bhcb_cmd_t      cmd_o
);

  import bhcb_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TRIM    = 3'd1;
  localparam logic [2:0] S_EXEC    = 3'd2;
  localparam logic [2:0] S_RD_PAIR = 3'd3;
  localparam logic [2:0] S_RD_TGT  = 3'd4;
  localparam logic [2:0] S_DONE    = 3'd5;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       accept;

  assign busy           = !((state_q == S_IDLE) || (state_q == S_DONE));
  assign accept         = start && !busy;
  assign result_valid_o = (state_q == S_DONE);

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = accept;
    cmd_o.trim    = (state_q == S_TRIM);
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.rd_pair = (state_q == S_RD_PAIR);
    cmd_o.rd_tgt  = (state_q == S_RD_TGT);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    state_d = accept ? S_TRIM : S_IDLE;
      S_TRIM:    state_d = S_EXEC;
      S_EXEC:    state_d = S_RD_PAIR;
      S_RD_PAIR: state_d = S_RD_TGT;
      S_RD_TGT:  state_d = S_DONE;
      S_DONE:    state_d = accept ? S_TRIM : S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("controller issued overlapping commands");

  a_trim_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.trim |=> cmd_o.exec)
    else $error("update step did not follow the trim step");

  a_result_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for more than one cycle");

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> busy && !result_valid_o)
    else $error("controller not busy after taking a request");
`endif

endmodule

`default_nettype wire

>>> rtl/bhcb_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bhcb_dp #(
  parameter int unsigned HISTORY_DEPTH = 1024,
  parameter int unsigned ENTRY_WIDTH   = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire bhcb_pkg::bhcb_cmd_t                   cmd_i,
  input  wire logic [bhcb_pkg::LIMIT_W-1:0]          limit_i,
  input  wire logic [bhcb_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic [bhcb_pkg::DATA_W-1:0]           entry_data_i,
  input  wire logic signed [bhcb_pkg::DELTA_W-1:0]   step_delta_i,
  input  wire logic [bhcb_pkg::INDEX_W-1:0]          target_index_i,
  output logic                                       accepted_o,
  output logic [bhcb_pkg::COUNT_W-1:0]               entry_count_o,
  output logic                                       cursor_valid_o,
  output logic [bhcb_pkg::INDEX_W-1:0]               cursor_index_o,
  output logic                                       current_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                current_data_o,
  output logic                                       neighbour_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                neighbour_data_o,
  output logic                                       read_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                read_data_o
);

  import bhcb_pkg::*;

  localparam int unsigned LIMIT_MAX = (1 << LIMIT_W) - 1;
  localparam int unsigned MAX_TOTAL = (HISTORY_DEPTH < LIMIT_MAX) ? HISTORY_DEPTH : LIMIT_MAX;
  localparam int unsigned AW        = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW        = $clog2(MAX_TOTAL + 1);
  localparam int unsigned SW        = ((AW > CW) ? AW : CW) + 1;
  localparam int unsigned MW        = ((CW > DELTA_W) ? CW : DELTA_W) + 2;
  localparam int unsigned XW        = (CW > INDEX_W) ? CW : INDEX_W;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(HISTORY_DEPTH)) begin
      sum = sum - SW'(HISTORY_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [REQ_W-1:0]          req_q;
  logic [DATA_W-1:0]         data_q;
  logic signed [DELTA_W-1:0] delta_q;
  logic [INDEX_W-1:0]        target_q;

  logic [AW-1:0] oldest_q, oldest_d;
  logic [CW-1:0] total_q, total_d;
  logic [CW-1:0] cursor_q, cursor_d;
  logic          back_q, back_d;
  logic          accepted_q, accepted_d;
  logic          rvalid_q, rvalid_d;
  logic          nb_valid_q;
  logic [DATA_W-1:0] cur_data_q;
  logic [DATA_W-1:0] nb_data_q;

  logic [ENTRY_WIDTH-1:0] mem [HISTORY_DEPTH];
  logic [ENTRY_WIDTH-1:0] mem_a_q;
  logic [ENTRY_WIDTH-1:0] mem_b_q;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [AW-1:0]          mem_addr_a;
  logic [AW-1:0]          mem_addr_b;

  logic [CW-1:0]        lim;
  logic [CW-1:0]        excess;
  logic                 full;
  logic signed [MW-1:0] move_t;
  logic                 move_ok;
  logic                 set_ok;
  logic                 set_back;
  logic                 held_any;
  logic [CW-1:0]        nb_off;
  logic                 nb_ok;

  always_comb begin
    if (limit_i < LIMIT_W'(MIN_LIMIT)) begin
      lim = CW'(MIN_LIMIT);
    end else if (limit_i > LIMIT_W'(MAX_TOTAL)) begin
      lim = CW'(MAX_TOTAL);
    end else begin
      lim = CW'(limit_i);
    end
  end

  assign held_any = (total_q != '0);
  assign excess   = total_q - lim;
  assign full     = (total_q >= lim);
  assign move_t   = $signed(MW'(cursor_q)) + MW'(delta_q);
  assign move_ok  = held_any && (delta_q != '0) && !move_t[MW-1]
                    && (move_t < $signed(MW'(total_q)));
  assign set_ok   = (XW'(target_q) < XW'(total_q));
  assign set_back = (XW'(target_q) < XW'(cursor_q));
  assign nb_off   = back_q ? (cursor_q - 1'b1) : (cursor_q + 1'b1);
  assign nb_ok    = held_any && (back_q ? (cursor_q != '0) : (nb_off < total_q));

  always_comb begin
    oldest_d   = oldest_q;
    total_d    = total_q;
    cursor_d   = cursor_q;
    back_d     = back_q;
    accepted_d = accepted_q;
    rvalid_d   = rvalid_q;
    mem_we     = 1'b0;
    mem_waddr  = slot_of(oldest_q, total_q);
    if (cmd_i.trim && (total_q > lim)) begin
      oldest_d = slot_of(oldest_q, excess);
      total_d  = lim;
      cursor_d = (cursor_q > excess) ? (cursor_q - excess) : '0;
    end
    if (cmd_i.exec) begin
      accepted_d = 1'b0;
      rvalid_d   = 1'b0;
      case (req_e'(req_q))
        REQ_PUSH: begin
          mem_we     = 1'b1;
          if (full) begin
            oldest_d = slot_of(oldest_q, CW'(1));
            cursor_d = total_q - 1'b1;
          end else begin
            total_d  = total_q + 1'b1;
            cursor_d = total_q;
          end
          back_d     = 1'b0;
          accepted_d = 1'b1;
        end
        REQ_MOVE: begin
          if (move_ok) begin
            cursor_d   = CW'(move_t);
            back_d     = delta_q[DELTA_W-1];
            accepted_d = 1'b1;
          end
        end
        REQ_SET: begin
          if (set_ok) begin
            back_d     = set_back;
            cursor_d   = CW'(target_q);
            accepted_d = 1'b1;
          end
        end
        REQ_READ: begin
          rvalid_d = set_ok;
        end
        REQ_CLEAR: begin
          total_d    = '0;
          oldest_d   = '0;
          cursor_d   = '0;
          accepted_d = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_addr_a = cmd_i.rd_tgt ? slot_of(oldest_q, CW'(target_q))
                                   : slot_of(oldest_q, cursor_q);
  assign mem_addr_b = slot_of(oldest_q, nb_off);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= ENTRY_WIDTH'(data_q);
    end
    if (cmd_i.rd_pair || cmd_i.rd_tgt) begin
      mem_a_q <= mem[mem_addr_a];
    end
    if (cmd_i.rd_pair) begin
      mem_b_q <= mem[mem_addr_b];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q    <= req_type_i;
      data_q   <= entry_data_i;
      delta_q  <= step_delta_i;
      target_q <= target_index_i;
    end
    accepted_q <= accepted_d;
    rvalid_q   <= rvalid_d;
    if (cmd_i.rd_pair) begin
      nb_valid_q <= nb_ok;
    end
    if (cmd_i.rd_tgt) begin
      cur_data_q <= held_any ? DATA_W'(mem_a_q) : '0;
      nb_data_q  <= nb_valid_q ? DATA_W'(mem_b_q) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q <= '0;
      total_q  <= '0;
      cursor_q <= '0;
      back_q   <= 1'b0;
    end else begin
      oldest_q <= oldest_d;
      total_q  <= total_d;
      cursor_q <= cursor_d;
      back_q   <= back_d;
    end
  end

  assign accepted_o        = accepted_q;
  assign entry_count_o     = COUNT_W'(total_q);
  assign cursor_valid_o    = held_any;
  assign cursor_index_o    = held_any ? INDEX_W'(cursor_q) : '0;
  assign current_valid_o   = held_any;
  assign current_data_o    = cur_data_q;
  assign neighbour_valid_o = nb_valid_q;
  assign neighbour_data_o  = nb_data_q;
  assign read_valid_o      = rvalid_q;
  assign read_data_o       = rvalid_q ? DATA_W'(mem_a_q) : '0;

`ifndef ASSERT_OFF
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(MAX_TOTAL))
    else $error("entry count exceeds the store capacity");

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != '0) |-> (cursor_q < total_q))
    else $error("cursor points past the newest entry");

  a_push_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && (req_q == REQ_PUSH)) |=>
      ((total_q != '0) && (cursor_q == CW'(total_q - 1'b1)) && !back_q))
    else $error("push did not leave the cursor on the newest entry");
`endif

endmodule

`default_nettype wire

>>> rtl/bounded_history_cursor_buffer_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Keeps a bounded history of entry handles with a cursor and a travel direction. A request
// is taken when start is high and busy is low, and its result is driven on the result ports
// for exactly one cycle with result_valid_o high, after the request has passed in turn
// through the trim, update, paired read and indexed read steps; the receiver cannot stall,
// so the result must be captured in that cycle. A new request may be taken in the cycle
// that shows the previous result, but not before it. The paired step reads the current and
// neighbour entries, the indexed step reads the entry at the target index, and all reads go
// through one history memory with two read ports. The memory
// needs no clearing pass after reset, since only entries below the held count are ever
// reported. The history limit register sits at byte address 0 and should be written only
// while no request is in flight; a lowered limit trims the oldest entries at the start of
// the next request.
module bounded_history_cursor_buffer_unit #(
  parameter int unsigned HISTORY_DEPTH = 1024,
  parameter int unsigned ENTRY_WIDTH   = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start,
  output logic                                       busy,
  output logic                                       result_valid_o,
  input  wire logic [bhcb_pkg::REQ_W-1:0]            req_type_i,
  input  wire logic [bhcb_pkg::DATA_W-1:0]           entry_data_i,
  input  wire logic signed [bhcb_pkg::DELTA_W-1:0]   step_delta_i,
  input  wire logic [bhcb_pkg::INDEX_W-1:0]          target_index_i,
  output logic                                       accepted_o,
  output logic [bhcb_pkg::COUNT_W-1:0]               entry_count_o,
  output logic                                       cursor_valid_o,
  output logic [bhcb_pkg::INDEX_W-1:0]               cursor_index_o,
  output logic                                       current_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                current_data_o,
  output logic                                       neighbour_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                neighbour_data_o,
  output logic                                       read_valid_o,
  output logic [bhcb_pkg::DATA_W-1:0]                read_data_o,
  input  wire logic                                  psel,
  input  wire logic                                  penable,
  input  wire logic                                  pwrite,
  input  wire logic [bhcb_pkg::APB_AW-1:0]           paddr,
  input  wire logic [bhcb_pkg::APB_DW-1:0]           pwdata,
  output logic [bhcb_pkg::APB_DW-1:0]                prdata,
  output logic                                       pready
);

  import bhcb_pkg::*;

  localparam logic REG_LIMIT = 1'b0;

  bhcb_cmd_t          cmd;
  logic [LIMIT_W-1:0] limit_q;
  logic               reg_sel;
  logic               limit_we;

  assign pready   = 1'b1;
  assign reg_sel  = (paddr[APB_AW-1] == REG_LIMIT);
  assign limit_we = psel && penable && pwrite && pready && reg_sel;
  assign prdata   = reg_sel ? APB_DW'(limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(LIMIT_RESET);
    end else if (limit_we) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  bhcb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .result_valid_o (result_valid_o),
    .cmd_o          (cmd)
  );

  bhcb_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .ENTRY_WIDTH   (ENTRY_WIDTH)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .limit_i           (limit_q),
    .req_type_i        (req_type_i),
    .entry_data_i      (entry_data_i),
    .step_delta_i      (step_delta_i),
    .target_index_i    (target_index_i),
    .accepted_o        (accepted_o),
    .entry_count_o     (entry_count_o),
    .cursor_valid_o    (cursor_valid_o),
    .cursor_index_o    (cursor_index_o),
    .current_valid_o   (current_valid_o),
    .current_data_o    (current_data_o),
    .neighbour_valid_o (neighbour_valid_o),
    .neighbour_data_o  (neighbour_data_o),
    .read_valid_o      (read_valid_o),
    .read_data_o       (read_data_o)
  );

endmodule

`default_nettype wire

>>> tb/bounded_history_cursor_buffer_unit_tb.sv
`timescale 1ns / 1ps

module bounded_history_cursor_buffer_unit_tb;
  import bhcb_pkg::*;

  localparam logic [APB_AW-1:0] LIMIT_ADDR      = '0;
  localparam logic [REQ_W-1:0]  REQ_SPARE_FIRST = 3'd5;
  localparam logic [REQ_W-1:0]  REQ_SPARE_LAST  = 3'd7;
  localparam int                DEPTH           = 1024;
  localparam int                CYCLE_LIMIT     = 400000;
  localparam int                DRAIN_LIMIT     = 200;
  localparam int                IDLE_PCT        = 31;
  localparam int                PHASE_ITEMS     = 90;

  typedef struct {
    logic               accepted;
    logic [COUNT_W-1:0] count;
    logic               cursor_valid;
    logic [INDEX_W-1:0] cursor_index;
    logic               current_valid;
    logic [DATA_W-1:0]  current_data;
    logic               neighbour_valid;
    logic [DATA_W-1:0]  neighbour_data;
    logic               read_valid;
    logic [DATA_W-1:0]  read_data;
  } outcome_t;

  class history_scoreboard;
    logic [DATA_W-1:0]  entries[$];
    int                 cursor;
    bit                 backward;
    logic [LIMIT_W-1:0] limit_reg;
    outcome_t           awaited[$];
    int                 failures;

    function new();
      cursor    = -1;
      backward  = 1'b0;
      limit_reg = LIMIT_W'(LIMIT_RESET);
      failures  = 0;
    endfunction

    function bit held(int idx);
      return idx >= 0 && idx < entries.size();
    endfunction

    function logic [DATA_W-1:0] entry_at(int idx);
      return held(idx) ? entries[idx] : '0;
    endfunction

    function void drop_oldest();
      entries.delete(0);
      if (cursor > 0) cursor--;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [DATA_W-1:0] data,
                               logic signed [DELTA_W-1:0] delta,
                               logic [INDEX_W-1:0] target);
      int       lim;
      int       step;
      int       idx;
      int       dest;
      int       nb;
      outcome_t o;
      o = '{default: '0};
      lim = limit_reg;
      if (lim < MIN_LIMIT) lim = MIN_LIMIT;
      if (lim > DEPTH) lim = DEPTH;
      step = delta;
      idx = target;
      while (entries.size() > lim) drop_oldest();
      case (req)
        REQ_PUSH: begin
          if (entries.size() >= lim) drop_oldest();
          entries = {entries, data};
          cursor = entries.size() - 1;
          backward = 1'b0;
          o.accepted = 1'b1;
        end
        REQ_MOVE: begin
          dest = cursor + step;
          if (entries.size() > 0 && step != 0 && held(dest)) begin
            cursor = dest;
            backward = step < 0;
            o.accepted = 1'b1;
          end
        end
        REQ_SET: begin
          if (held(idx)) begin
            backward = idx < cursor;
            cursor = idx;
            o.accepted = 1'b1;
          end
        end
        REQ_READ: begin
          if (held(idx)) begin
            o.read_valid = 1'b1;
            o.read_data = entries[idx];
          end
        end
        REQ_CLEAR: begin
          entries.delete();
          cursor = -1;
          o.accepted = 1'b1;
        end
        default: begin
        end
      endcase
      nb = backward ? cursor - 1 : cursor + 1;
      o.count = COUNT_W'(entries.size());
      o.cursor_valid = held(cursor);
      o.cursor_index = held(cursor) ? INDEX_W'(cursor) : '0;
      o.current_valid = held(cursor);
      o.current_data = entry_at(cursor);
      o.neighbour_valid = held(nb);
      o.neighbour_data = entry_at(nb);
      awaited = {awaited, o};
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        failures++;
      end
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with no request outstanding", $time);
        failures++;
        return;
      end
      want = awaited[0];
      awaited.delete(0);
      compare_field("accepted", want.accepted, got.accepted);
      compare_field("entry_count", want.count, got.count);
      compare_field("cursor_valid", want.cursor_valid, got.cursor_valid);
      compare_field("cursor_index", want.cursor_index, got.cursor_index);
      compare_field("current_valid", want.current_valid, got.current_valid);
      compare_field("current_data", want.current_data, got.current_data);
      compare_field("neighbour_valid", want.neighbour_valid, got.neighbour_valid);
      compare_field("neighbour_data", want.neighbour_data, got.neighbour_data);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("read_data", want.read_data, got.read_data);
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic                      result_valid_o;
  logic [REQ_W-1:0]          req_type_i;
  logic [DATA_W-1:0]         entry_data_i;
  logic signed [DELTA_W-1:0] step_delta_i;
  logic [INDEX_W-1:0]        target_index_i;
  logic                      accepted_o;
  logic [COUNT_W-1:0]        entry_count_o;
  logic                      cursor_valid_o;
  logic [INDEX_W-1:0]        cursor_index_o;
  logic                      current_valid_o;
  logic [DATA_W-1:0]         current_data_o;
  logic                      neighbour_valid_o;
  logic [DATA_W-1:0]         neighbour_data_o;
  logic                      read_valid_o;
  logic [DATA_W-1:0]         read_data_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  history_scoreboard sb;
  int                idle_pct;
  int unsigned       cycles = 0;

  bounded_history_cursor_buffer_unit u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .result_valid_o    (result_valid_o),
    .req_type_i        (req_type_i),
    .entry_data_i      (entry_data_i),
    .step_delta_i      (step_delta_i),
    .target_index_i    (target_index_i),
    .accepted_o        (accepted_o),
    .entry_count_o     (entry_count_o),
    .cursor_valid_o    (cursor_valid_o),
    .cursor_index_o    (cursor_index_o),
    .current_valid_o   (current_valid_o),
    .current_data_o    (current_data_o),
    .neighbour_valid_o (neighbour_valid_o),
    .neighbour_data_o  (neighbour_data_o),
    .read_valid_o      (read_valid_o),
    .read_data_o       (read_data_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin : watch_results
    outcome_t got;
    if (rst_ni && result_valid_o) begin
      got.accepted        = accepted_o;
      got.count           = entry_count_o;
      got.cursor_valid    = cursor_valid_o;
      got.cursor_index    = cursor_index_o;
      got.current_valid   = current_valid_o;
      got.current_data    = current_data_o;
      got.neighbour_valid = neighbour_valid_o;
      got.neighbour_data  = neighbour_data_o;
      got.read_valid      = read_valid_o;
      got.read_data       = read_data_o;
      sb.check_result(got);
    end
  end

  // Called at a falling edge; returns at a falling edge with nothing yet driven there.
  task automatic send_request(input logic [REQ_W-1:0] req, input logic [DATA_W-1:0] data,
                              input logic signed [DELTA_W-1:0] delta,
                              input logic [INDEX_W-1:0] target);
    start          <= 1'b1;
    req_type_i     <= req;
    entry_data_i   <= data;
    step_delta_i   <= delta;
    target_index_i <= target;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(req, data, delta, target);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start          <= 1'b0;
      req_type_i     <= REQ_W'($urandom);
      entry_data_i   <= $urandom;
      step_delta_i   <= DELTA_W'($urandom);
      target_index_i <= INDEX_W'($urandom);
      @(negedge clk_i);
    end
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (sb.awaited.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[LIMIT_W-1:0] = value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.limit_reg = word[LIMIT_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic random_request();
    int                        pick;
    int                        n;
    logic [DATA_W-1:0]         data;
    logic signed [DELTA_W-1:0] d;
    logic [INDEX_W-1:0]        tgt;
    n = sb.entries.size();
    pick = $urandom_range(99);
    data = $urandom;
    if ($urandom_range(15) == 0) data = $urandom_range(1) ? '1 : '0;
    if ($urandom_range(7) == 0) d = DELTA_W'($urandom);
    else d = DELTA_W'(int'($urandom_range(8)) - 4);
    if ($urandom_range(9) == 0) tgt = INDEX_W'($urandom);
    else tgt = INDEX_W'($urandom_range(n + 1));
    if (pick < 36) send_request(REQ_PUSH, data, d, tgt);
    else if (pick < 57) send_request(REQ_MOVE, data, d, tgt);
    else if (pick < 70) send_request(REQ_SET, data, d, tgt);
    else if (pick < 89) send_request(REQ_READ, data, d, tgt);
    else if (pick < 92) send_request(REQ_CLEAR, data, d, tgt);
    else if (pick < 96)
      send_request(REQ_SPARE_FIRST + REQ_W'($urandom_range(2)), data, d, tgt);
    else send_request(REQ_W'($urandom), data, d, tgt);
  endtask

  logic [LIMIT_W-1:0] phase_limits[8] = '{11'd8, 11'd9, 11'd1000, 11'd3, 11'd1024, 11'd16,
                                          11'd1023, 11'd0};

  initial begin
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = '0;
    entry_data_i   = '0;
    step_delta_i   = '0;
    target_index_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    idle_pct       = IDLE_PCT;
    sb             = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request(REQ_READ, '0, '0, '0);
    send_request(REQ_MOVE, '0, DELTA_W'(1), '0);
    send_request(REQ_SET, '0, '0, '0);
    send_request(REQ_PUSH, '0, '0, '0);
    send_request(REQ_PUSH, '1, '0, '0);
    send_request(REQ_PUSH, 32'h5a5a_a5a5, '0, '1);
    send_request(REQ_MOVE, '0, '0, '0);
    send_request(REQ_MOVE, '0, DELTA_W'(-1023), '0);
    send_request(REQ_MOVE, '0, DELTA_W'(1023), '0);
    send_request(REQ_MOVE, '0, 11'h400, '0);
    send_request(REQ_MOVE, '0, DELTA_W'(-2), '0);
    send_request(REQ_MOVE, '0, DELTA_W'(1), '0);
    send_request(REQ_SET, '0, '0, INDEX_W'(2));
    send_request(REQ_SET, '0, '0, INDEX_W'(2));
    send_request(REQ_SET, '0, '0, '0);
    send_request(REQ_SET, '0, '0, INDEX_W'(3));
    send_request(REQ_SET, '0, '0, '1);
    send_request(REQ_READ, '0, '0, INDEX_W'(2));
    send_request(REQ_READ, '0, '0, INDEX_W'(3));
    send_request(REQ_READ, '0, '0, '1);
    for (int r = REQ_SPARE_FIRST; r <= REQ_SPARE_LAST; r++)
      send_request(REQ_W'(r), $urandom, DELTA_W'($urandom), INDEX_W'($urandom));
    send_request(REQ_CLEAR, '0, '0, '0);
    send_request(REQ_READ, '0, '0, '0);
    send_request(REQ_PUSH, $urandom, '0, '0);

    // Grow a short history, probe its ends, then drop the limit below its floor.
    repeat (40) send_request(REQ_PUSH, $urandom, '0, '0);
    send_request(REQ_READ, '0, '0, '1);
    send_request(REQ_READ, '0, '0, '0);
    send_request(REQ_SET, '0, '0, '1);
    send_request(REQ_MOVE, '0, DELTA_W'(-1023), '0);
    send_request(REQ_MOVE, '0, DELTA_W'(1023), '0);
    send_request(REQ_MOVE, '0, DELTA_W'(1), '0);
    send_request(REQ_MOVE, '0, 11'h400, '0);
    send_request(REQ_SET, '0, '0, INDEX_W'(20));
    drain();
    write_limit('0);
    send_request(REQ_READ, '0, '0, INDEX_W'(7));
    send_request(REQ_PUSH, $urandom, '0, '0);

    foreach (phase_limits[p]) begin
      drain();
      write_limit(phase_limits[p]);
      idle_pct = (p == 2) ? 0 : IDLE_PCT;
      repeat (PHASE_ITEMS) random_request();
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.failures == 0 && sb.awaited.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
